[design/drbl_pkg.sv]
package drbl_pkg;

   localparam int unsigned NUM_BANKS = 16;
   localparam int unsigned BANK_BITS = 4;
   localparam int unsigned ROW_BYTES = 1024;
   localparam logic [3:0] ROW_LOG2 = 4'd10;

   localparam int unsigned ADDR_W = 48;
   localparam int unsigned ROW_W = ADDR_W - BANK_BITS;
   localparam int unsigned CNT_W = 48;
   localparam int unsigned LAT_W = 8;

   localparam logic [LAT_W-1:0] T_ACT = 8'd45;
   localparam logic [LAT_W-1:0] T_CAS = 8'd45;
   localparam logic [LAT_W-1:0] T_PRE = 8'd45;
   localparam logic [LAT_W-1:0] T_BUS = 8'd10;
   localparam logic [LAT_W-1:0] T_FIXED = 8'd100;

   localparam logic [LAT_W-1:0] LAT_HIT = T_CAS + T_BUS;
   localparam logic [LAT_W-1:0] LAT_EMPTY = T_ACT + T_CAS + T_BUS;
   localparam logic [LAT_W-1:0] LAT_CONFLICT = T_PRE + T_ACT + T_CAS + T_BUS;

   typedef enum logic [2:0] {
      OUT_HIT      = 3'd0,
      OUT_EMPTY    = 3'd1,
      OUT_CONFLICT = 3'd2,
      OUT_CLOSED   = 3'd3,
      OUT_FIXED    = 3'd4
   } outcome_type;

   typedef enum logic [1:0] {
      CSR_FIXED_MODE = 2'd0,
      CSR_CLOSE_PAGE = 2'd1,
      CSR_LINE_LOG2  = 2'd2
   } csr_index_type;

endpackage

[design/dram_row_buffer_latency_unit.sv]
// An accepted request passes through the input register and then the result
// register, whose output drives rsp_valid.
// Throughput: one request per cycle unless rsp_stall holds back a result; the bank table and counters are read and
// updated in the single pass between the two registers.
// Reset (synchronous): clears pipeline valids, bank valid bits and all counters,
// and sets the mode registers to open page, no fixed latency, 64-byte lines.
module dram_row_buffer_latency_unit (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [47:0] req_line_address,
   input  logic        req_is_write,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_latency,
   output logic [2:0]  rsp_outcome,
   output logic [47:0] rsp_reads_so_far,
   output logic [47:0] rsp_writes_so_far,
   output logic [47:0] rsp_read_delay_sum,
   output logic [47:0] rsp_write_delay_sum,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   function automatic logic [drbl_pkg::CNT_W-1:0] sat_add(
      input logic [drbl_pkg::CNT_W-1:0] a,
      input logic [drbl_pkg::LAT_W-1:0] b
   );
      logic [drbl_pkg::CNT_W:0] s;
      s = {1'b0, a} + {{(drbl_pkg::CNT_W + 1 - drbl_pkg::LAT_W){1'b0}}, b};
      return s[drbl_pkg::CNT_W] ? {drbl_pkg::CNT_W{1'b1}} : s[drbl_pkg::CNT_W-1:0];
   endfunction

   // configuration registers
   logic       fixed_mode_ff;
   logic       close_page_ff;
   logic [3:0] line_log2_ff;
   logic       csr_write;

   // input stage
   logic                         s1_valid_ff, s1_valid_in;
   logic [drbl_pkg::ADDR_W-1:0]  s1_addr_ff;
   logic                         s1_wr_ff;

   // result stage
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [drbl_pkg::LAT_W-1:0]   rsp_latency_ff, rsp_latency_in;
   drbl_pkg::outcome_type        rsp_outcome_ff, rsp_outcome_in;

   // bank state
   logic [drbl_pkg::ROW_W-1:0]     bank_row_ff [drbl_pkg::NUM_BANKS];
   logic [drbl_pkg::NUM_BANKS-1:0] bank_valid_ff;

   logic [drbl_pkg::CNT_W-1:0] read_count_ff, read_count_in;
   logic [drbl_pkg::CNT_W-1:0] write_count_ff, write_count_in;
   logic [drbl_pkg::CNT_W-1:0] read_total_ff, read_total_in;
   logic [drbl_pkg::CNT_W-1:0] write_total_ff, write_total_in;

   logic                         out_free;
   logic                         advance;
   logic                         accept;
   logic [3:0]                   shift_amt;
   logic [drbl_pkg::ADDR_W-1:0]  blk;
   logic [drbl_pkg::BANK_BITS-1:0] bank;
   logic [drbl_pkg::ROW_W-1:0]   row;
   logic                         open_mode;
   logic                         row_load;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_mode_ff <= 1'b0;
         close_page_ff <= 1'b0;
         line_log2_ff <= 4'd6;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            drbl_pkg::CSR_FIXED_MODE: fixed_mode_ff <= pwdata[0];
            drbl_pkg::CSR_CLOSE_PAGE: close_page_ff <= pwdata[0];
            drbl_pkg::CSR_LINE_LOG2: line_log2_ff <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         drbl_pkg::CSR_FIXED_MODE: prdata = {31'd0, fixed_mode_ff};
         drbl_pkg::CSR_CLOSE_PAGE: prdata = {31'd0, close_page_ff};
         drbl_pkg::CSR_LINE_LOG2: prdata = {28'd0, line_log2_ff};
         default: prdata = 32'd0;
      endcase
   end

   // ---------------- handshake ----------------
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept = req_valid && !req_stall;

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff <= req_line_address;
         s1_wr_ff <= req_is_write;
      end
   end

   // ---------------- row classification ----------------
   // lines per row is a power of two; a line as large as a row maps one line per row
   assign shift_amt = (line_log2_ff >= drbl_pkg::ROW_LOG2) ? 4'd0
                      : drbl_pkg::ROW_LOG2 - line_log2_ff;
   assign blk = s1_addr_ff >> shift_amt;
   assign bank = blk[drbl_pkg::BANK_BITS-1:0];
   assign row = blk[drbl_pkg::ADDR_W-1:drbl_pkg::BANK_BITS];
   assign open_mode = !fixed_mode_ff && !close_page_ff;

   always_comb begin
      row_load = 1'b0;
      if (fixed_mode_ff) begin
         rsp_latency_in = drbl_pkg::T_FIXED;
         rsp_outcome_in = drbl_pkg::OUT_FIXED;
      end else if (close_page_ff) begin
         rsp_latency_in = drbl_pkg::LAT_EMPTY;
         rsp_outcome_in = drbl_pkg::OUT_CLOSED;
      end else if (!bank_valid_ff[bank]) begin
         rsp_latency_in = drbl_pkg::LAT_EMPTY;
         rsp_outcome_in = drbl_pkg::OUT_EMPTY;
         row_load = 1'b1;
      end else if (bank_row_ff[bank] != row) begin
         rsp_latency_in = drbl_pkg::LAT_CONFLICT;
         rsp_outcome_in = drbl_pkg::OUT_CONFLICT;
         row_load = 1'b1;
      end else begin
         rsp_latency_in = drbl_pkg::LAT_HIT;
         rsp_outcome_in = drbl_pkg::OUT_HIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_valid_ff <= '0;
      end else if (advance && open_mode) begin
         bank_valid_ff[bank] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && open_mode && row_load) begin
         bank_row_ff[bank] <= row;
      end
   end

   // ---------------- statistics ----------------
   always_comb begin
      read_count_in = read_count_ff;
      write_count_in = write_count_ff;
      read_total_in = read_total_ff;
      write_total_in = write_total_ff;
      if (s1_wr_ff) begin
         write_count_in = sat_add(write_count_ff, 8'd1);
         write_total_in = sat_add(write_total_ff, rsp_latency_in);
      end else begin
         read_count_in = sat_add(read_count_ff, 8'd1);
         read_total_in = sat_add(read_total_ff, rsp_latency_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_count_ff <= '0;
         write_count_ff <= '0;
         read_total_ff <= '0;
         write_total_ff <= '0;
      end else if (advance) begin
         read_count_ff <= read_count_in;
         write_count_ff <= write_count_in;
         read_total_ff <= read_total_in;
         write_total_ff <= write_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_latency_ff <= rsp_latency_in;
         rsp_outcome_ff <= rsp_outcome_in;
      end
   end

   // counters only move when a new result loads, so they double as its fields
   assign rsp_valid = rsp_valid_ff;
   assign rsp_latency = rsp_latency_ff;
   assign rsp_outcome = rsp_outcome_ff;
   assign rsp_reads_so_far = read_count_ff;
   assign rsp_writes_so_far = write_count_ff;
   assign rsp_read_delay_sum = read_total_ff;
   assign rsp_write_delay_sum = write_total_ff;

`ifndef SYNTHESIS
   a_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (($past(bank_valid_ff) & ~bank_valid_ff) == '0))
      else $error("bank valid bit cleared outside reset");

   a_banks_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && !open_mode) |=> $stable(bank_valid_ff))
      else $error("bank state changed outside open-page mode");

   a_hit_latency: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_outcome_ff == drbl_pkg::OUT_HIT)
         |-> (rsp_latency_ff == drbl_pkg::LAT_HIT))
      else $error("row hit with wrong latency");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request lost at input stage");

   a_empty_after: assert property (@(posedge clock) disable iff (reset)
      (advance && open_mode) |=> bank_valid_ff[$past(bank)])
      else $error("open-page access left its bank invalid");
`endif

endmodule
